>>> src/pbta_pkg.sv
// Package for the paged block table allocator: widths, codes, states and result type.
package pbta_pkg;

  // Default sizing of the page stack and the block table
  localparam int unsigned MaxPagesDef  = 256;
  localparam int unsigned MaxBlocksDef = 32;

  // Field widths
  localparam int unsigned PAGE_W     = 8;
  localparam int unsigned LIMIT_W    = 9;
  localparam int unsigned PSIZE_W    = 13;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned END_W      = 17;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQ    = 2'd2;

  // Configuration reset values
  localparam logic [LIMIT_W-1:0] PageLimitRst = 9'd256;
  localparam logic [PSIZE_W-1:0] PageSizeRst  = 13'd16;
  localparam logic [SEQ_W-1:0]   MaxSeqRst    = 16'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_PREP  = 2'd2,
    OP_REL   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_STACK_FULL = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_PREP_CHK,
    S_PREP_STEP,
    S_TAKE,
    S_REL_RD,
    S_REL_PUSH,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] page_id;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] length;
    status_e           status;
    logic              last;
  } res_t;

endpackage

>>> src/paged_block_table_allocator_unit.sv
// Paged block table allocator: free page stack, page minting and one sequence block table.
// Alloc and free pass through their own state to the result word; an alloc that pops the stack adds a take state.
// Prepare checks the range, then appends one page per step, minting it or popping and taking it.
// Release reads each table entry, then writes it to the stack, and reports after the last entry.
// One item is in flight; the next word is taken the cycle after the final result loads.
// Reset clears all counts and loads the register defaults; the memories need no clearing.
module paged_block_table_allocator_unit #(
  parameter int unsigned NUM_PAGES  = pbta_pkg::MaxPagesDef,
  parameter int unsigned MAX_BLOCKS = pbta_pkg::MaxBlocksDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pbta_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbta_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: page [7:0], pos0 [23:8], tokens [39:24]
  input  logic [pbta_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: operation [1:0]
  input  logic [pbta_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: page_id [7:0], table_slot [13:8], table_length [19:14], status [22:20], zero [23]
  output logic [pbta_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);
  import pbta_pkg::*;

  localparam int unsigned FreeCntW = $clog2(NUM_PAGES + 1);
  localparam int unsigned StackAw  = $clog2(NUM_PAGES);
  localparam int unsigned TblCntW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned TblAw    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CovW     = TblCntW + PSIZE_W;
  localparam int unsigned CmpW     = (CovW > END_W) ? CovW : END_W;

  // Configuration registers
  logic [LIMIT_W-1:0] page_limit_q;
  logic [PSIZE_W-1:0] page_size_q;
  logic [SEQ_W-1:0]   max_seq_q;

  // Control state
  state_e               state_q, state_d;
  logic [FreeCntW-1:0]  free_cnt_q, free_cnt_d;
  logic [LIMIT_W-1:0]   mint_cnt_q, mint_cnt_d;
  logic [TblCntW-1:0]   tbl_cnt_q, tbl_cnt_d;
  logic                 out_valid_q, out_valid_d;

  // Item and work registers
  op_e                  op_q, op_d;
  logic [PAGE_W-1:0]    page_q, page_d;
  logic [END_W-1:0]     end_q, end_d;
  logic [CovW-1:0]      cov_q, cov_d;
  logic [TblCntW-1:0]   rel_idx_q, rel_idx_d;
  status_e              rel_st_q, rel_st_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;

  // Memories and their ports
  logic [PAGE_W-1:0]    stack_mem [NUM_PAGES];
  logic [PAGE_W-1:0]    table_mem [MAX_BLOCKS];
  logic                 st_we, st_re, tb_we, tb_re;
  logic [StackAw-1:0]   st_waddr, st_raddr;
  logic [TblAw-1:0]     tb_waddr, tb_raddr;
  logic [PAGE_W-1:0]    st_wdata, tb_wdata;
  logic [PAGE_W-1:0]    st_rdata_q, tb_rdata_q;

  // Derived conditions
  op_e                  in_op;
  logic [PSIZE_W-1:0]   ps_eff;
  logic [LIMIT_W-1:0]   mint_lim;
  logic                 can_mint, stack_nonempty, stack_full, tbl_full;
  logic                 need_more, too_long, rel_more, out_free, in_accept;
  logic [StackAw-1:0]   pop_addr, push_addr;

  assign in_op          = op_e'(s_axis_tuser_i);
  assign in_accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign ps_eff         = (page_size_q == '0) ? PSIZE_W'(1) : page_size_q;
  assign can_mint       = mint_cnt_q < mint_lim;
  assign stack_nonempty = free_cnt_q != '0;
  assign stack_full     = free_cnt_q == FreeCntW'(NUM_PAGES);
  assign tbl_full       = tbl_cnt_q == TblCntW'(MAX_BLOCKS);
  assign need_more      = CmpW'(end_q) > CmpW'(cov_q);
  assign too_long       = end_q > END_W'(max_seq_q);
  assign rel_more       = rel_idx_q < tbl_cnt_q;
  assign out_free       = !out_valid_q || m_axis_tready_i;
  assign pop_addr       = StackAw'(free_cnt_q - FreeCntW'(1));
  assign push_addr      = StackAw'(free_cnt_q);

  // Clamp the mint limit to the stack depth
  always_comb begin
    if (32'(page_limit_q) < NUM_PAGES) begin
      mint_lim = page_limit_q;
    end else begin
      mint_lim = LIMIT_W'(NUM_PAGES);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          case (in_op)
            OP_ALLOC: state_d = S_ALLOC;
            OP_FREE:  state_d = S_FREE;
            OP_PREP:  state_d = S_PREP_CHK;
            default:  state_d = S_REL_RD;
          endcase
        end
      end
      S_ALLOC:     state_d = stack_nonempty ? S_TAKE : S_EMIT;
      S_FREE:      state_d = S_EMIT;
      S_PREP_CHK:  state_d = too_long ? S_EMIT : S_PREP_STEP;
      S_PREP_STEP: begin
        if (need_more && !tbl_full && stack_nonempty) begin
          state_d = S_TAKE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_TAKE:      state_d = S_EMIT;
      S_REL_RD:    state_d = rel_more ? S_REL_PUSH : S_EMIT;
      S_REL_PUSH:  state_d = S_REL_RD;
      S_EMIT: begin
        if (out_free) begin
          state_d = res_q.last ? S_IDLE : S_PREP_STEP;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath, memory ports and result register
  always_comb begin
    free_cnt_d  = free_cnt_q;
    mint_cnt_d  = mint_cnt_q;
    tbl_cnt_d   = tbl_cnt_q;
    op_d        = op_q;
    page_d      = page_q;
    end_d       = end_q;
    cov_d       = cov_q;
    rel_idx_d   = rel_idx_q;
    rel_st_d    = rel_st_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    st_we       = 1'b0;
    st_re       = 1'b0;
    tb_we       = 1'b0;
    tb_re       = 1'b0;
    st_waddr    = push_addr;
    st_raddr    = pop_addr;
    st_wdata    = page_q;
    tb_waddr    = TblAw'(tbl_cnt_q);
    tb_raddr    = TblAw'(rel_idx_q);
    tb_wdata    = st_rdata_q;

    case (state_q)
      // Latch the incoming word
      S_IDLE: begin
        if (in_accept) begin
          op_d      = in_op;
          page_d    = s_axis_tdata_i[PAGE_W-1:0];
          end_d     = END_W'(s_axis_tdata_i[23:8]) + END_W'(s_axis_tdata_i[39:24]);
          rel_idx_d = '0;
          rel_st_d  = ST_OK;
        end
      end
      // Pop the stack, else mint, else report exhaustion
      S_ALLOC: begin
        res_d = '{page_id: '0, slot: '0, length: SLOT_W'(tbl_cnt_q),
                  status: ST_OK, last: 1'b1};
        if (stack_nonempty) begin
          st_re      = 1'b1;
          free_cnt_d = free_cnt_q - FreeCntW'(1);
        end else if (can_mint) begin
          res_d.page_id = mint_cnt_q[PAGE_W-1:0];
          mint_cnt_d    = mint_cnt_q + LIMIT_W'(1);
        end else begin
          res_d.status = ST_EXHAUSTED;
        end
      end
      // Check the id and push it unless the stack is full
      S_FREE: begin
        res_d = '{page_id: page_q, slot: '0, length: SLOT_W'(tbl_cnt_q),
                  status: ST_OK, last: 1'b1};
        if (LIMIT_W'(page_q) >= mint_cnt_q) begin
          res_d.status = ST_UNKNOWN;
        end else if (stack_full) begin
          res_d.status = ST_STACK_FULL;
        end else begin
          st_we      = 1'b1;
          free_cnt_d = free_cnt_q + FreeCntW'(1);
        end
      end
      // Reject a range past the limit; compute the tokens already covered
      S_PREP_CHK: begin
        res_d = '{page_id: '0, slot: '0, length: SLOT_W'(tbl_cnt_q),
                  status: ST_TOO_LONG, last: 1'b1};
        cov_d = CovW'(tbl_cnt_q) * CovW'(ps_eff);
      end
      // Append one page while the table falls short of the range end
      S_PREP_STEP: begin
        res_d = '{page_id: '0, slot: '0, length: SLOT_W'(tbl_cnt_q),
                  status: ST_OK, last: 1'b1};
        if (need_more) begin
          if (tbl_full) begin
            res_d.status = ST_TABLE_FULL;
          end else if (stack_nonempty) begin
            st_re      = 1'b1;
            free_cnt_d = free_cnt_q - FreeCntW'(1);
            res_d.slot = SLOT_W'(tbl_cnt_q);
            res_d.last = 1'b0;
          end else if (can_mint) begin
            tb_we         = 1'b1;
            tb_wdata      = mint_cnt_q[PAGE_W-1:0];
            mint_cnt_d    = mint_cnt_q + LIMIT_W'(1);
            tbl_cnt_d     = tbl_cnt_q + TblCntW'(1);
            cov_d         = cov_q + CovW'(ps_eff);
            res_d.page_id = mint_cnt_q[PAGE_W-1:0];
            res_d.slot    = SLOT_W'(tbl_cnt_q);
            res_d.length  = SLOT_W'(tbl_cnt_q) + SLOT_W'(1);
            res_d.last    = 1'b0;
          end else begin
            res_d.status = ST_EXHAUSTED;
          end
        end
      end
      // Take the popped id; a prepare also writes it into the table
      S_TAKE: begin
        res_d.page_id = st_rdata_q;
        if (op_q == OP_PREP) begin
          tb_we        = 1'b1;
          tbl_cnt_d    = tbl_cnt_q + TblCntW'(1);
          cov_d        = cov_q + CovW'(ps_eff);
          res_d.length = SLOT_W'(tbl_cnt_q) + SLOT_W'(1);
        end
      end
      // Read the next table entry, or empty the table and report
      S_REL_RD: begin
        if (rel_more) begin
          tb_re = 1'b1;
        end else begin
          tbl_cnt_d = '0;
          res_d = '{page_id: '0, slot: '0, length: '0, status: rel_st_q, last: 1'b1};
        end
      end
      // Push the entry just read, drop it when the stack is full
      S_REL_PUSH: begin
        rel_idx_d = rel_idx_q + TblCntW'(1);
        if (stack_full) begin
          rel_st_d = ST_STACK_FULL;
        end else begin
          st_we      = 1'b1;
          st_wdata   = tb_rdata_q;
          free_cnt_d = free_cnt_q + FreeCntW'(1);
        end
      end
      default: begin
      end
    endcase

    // Output register: drain on ready, load the pending result
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_EMIT && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_cnt_q   <= '0;
      mint_cnt_q   <= '0;
      tbl_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      page_limit_q <= PageLimitRst;
      page_size_q  <= PageSizeRst;
      max_seq_q    <= MaxSeqRst;
    end else begin
      state_q     <= state_d;
      free_cnt_q  <= free_cnt_d;
      mint_cnt_q  <= mint_cnt_d;
      tbl_cnt_q   <= tbl_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_LIMIT: page_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_PAGE_SIZE:  page_size_q  <= cfg_wdata_i[PSIZE_W-1:0];
          CFG_MAX_SEQ:    max_seq_q    <= cfg_wdata_i[SEQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    page_q    <= page_d;
    end_q     <= end_d;
    cov_q     <= cov_d;
    rel_idx_q <= rel_idx_d;
    rel_st_q  <= rel_st_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Free stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= stack_mem[st_raddr];
    end
  end

  // Block table memory, registered read
  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      table_mem[tb_waddr] <= tb_wdata;
    end
    if (tb_re) begin
      tb_rdata_q <= table_mem[tb_raddr];
    end
  end

  // Ports
  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.status, out_q.length, out_q.slot, out_q.page_id};
  assign m_axis_tlast_o  = out_q.last;

  // Only the final word of an item may wait while the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && out_valid_q) |-> out_q.last)
    else $error("non-final result word pending while idle");

  // The free count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (free_cnt_q == $past(free_cnt_q) ||
              free_cnt_q == $past(free_cnt_q) + FreeCntW'(1) ||
              free_cnt_q == $past(free_cnt_q) - FreeCntW'(1)))
    else $error("free count jumped");

  // The table grows one entry at a time and empties only at the end of a release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_cnt_q != $past(tbl_cnt_q)) |->
      (tbl_cnt_q == $past(tbl_cnt_q) + TblCntW'(1) ||
       (tbl_cnt_q == '0 && $past(state_q) == S_REL_RD)))
    else $error("block table count changed unexpectedly");

endmodule
